// File: hw/rtl/mfba_pkg.sv
// shared types and constants of the max-flow block
package mfba_pkg;

  localparam int NodeW  = 6;
  localparam int Nodes  = 1 << NodeW;
  localparam int EdgeW  = 9;
  localparam int PairW  = EdgeW - 1;
  localparam int Pairs  = 1 << PairW;
  localparam int CapW   = 31;
  localparam int FlowW  = 32;
  localparam int AccW   = 41;
  localparam int NcntW  = 7;
  localparam int InfoW  = 2 * NodeW + CapW;

  localparam logic [1:0] ACT_ADD   = 2'd0;
  localparam logic [1:0] ACT_RUN   = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic latch;
    logic add_try;
    logic clr;
    logic init;
    logic deq;
    logic scan_go;
    logic scan_sum;
    logic path_go;
    logic restart;
    logic edge_rd;
    logic step;
    logic set_resp;
  } cmd_t;

  typedef struct packed {
    logic [1:0] act;
    logic       in_range;
    logic       src_eq_dst;
    logic       q_empty;
    logic       hit_dst;
    logic       scan_busy;
    logic       loc_is_src;
    logic       aug;
  } sts_t;

endpackage

// File: hw/rtl/mfba_ctrl.sv
// controller state machine of the max-flow block
module mfba_ctrl
  import mfba_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  output logic out_valid_o,
  input  logic out_ready_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_DEC  = 4'd1;
  localparam logic [3:0] S_DEQ  = 4'd2;
  localparam logic [3:0] S_DEQW = 4'd3;
  localparam logic [3:0] S_SCAN = 4'd4;
  localparam logic [3:0] S_WALK = 4'd5;
  localparam logic [3:0] S_PAR  = 4'd6;
  localparam logic [3:0] S_EDGE = 4'd7;
  localparam logic [3:0] S_SUM  = 4'd8;
  localparam logic [3:0] S_RESP = 4'd9;

  logic [3:0] state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_RESP);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.latch = 1'b1;
          state_d     = S_DEC;
        end
      end
      S_DEC: begin
        if (sts_i.act == ACT_RUN && sts_i.in_range) begin
          if (sts_i.src_eq_dst) begin
            cmd_o.scan_go  = 1'b1;
            cmd_o.scan_sum = 1'b1;
            state_d        = S_SUM;
          end else begin
            cmd_o.init = 1'b1;
            state_d    = S_DEQ;
          end
        end else begin
          cmd_o.add_try  = (sts_i.act == ACT_ADD);
          cmd_o.clr      = (sts_i.act == ACT_CLEAR);
          cmd_o.set_resp = 1'b1;
          state_d        = S_RESP;
        end
      end
      S_DEQ: begin
        if (sts_i.q_empty) begin
          cmd_o.scan_go  = 1'b1;
          cmd_o.scan_sum = 1'b1;
          state_d        = S_SUM;
        end else begin
          state_d = S_DEQW;
        end
      end
      S_DEQW: begin
        cmd_o.deq = 1'b1;
        if (sts_i.hit_dst) begin
          cmd_o.path_go = 1'b1;
          state_d       = S_WALK;
        end else begin
          cmd_o.scan_go = 1'b1;
          state_d       = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!sts_i.scan_busy) begin
          state_d = S_DEQ;
        end
      end
      S_WALK: begin
        if (sts_i.loc_is_src) begin
          if (!sts_i.aug) begin
            cmd_o.restart = 1'b1;
          end else begin
            cmd_o.init = 1'b1;
            state_d    = S_DEQ;
          end
        end else begin
          state_d = S_PAR;
        end
      end
      S_PAR: begin
        cmd_o.edge_rd = 1'b1;
        state_d       = S_EDGE;
      end
      S_EDGE: begin
        cmd_o.step = 1'b1;
        state_d    = S_WALK;
      end
      S_SUM: begin
        if (!sts_i.scan_busy) begin
          cmd_o.set_resp = 1'b1;
          state_d        = S_RESP;
        end
      end
      S_RESP: begin
        if (out_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// File: hw/rtl/mfba_dpath.sv
// datapath of the max-flow block: edge table, search scratch, sums
module mfba_dpath
  import mfba_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cmd_t             cmd_i,
  output sts_t             sts_o,
  input  logic             cfg_we_i,
  input  logic [NcntW-1:0] cfg_data_i,
  input  logic [1:0]       act_i,
  input  logic [NodeW-1:0] from_i,
  input  logic [NodeW-1:0] to_i,
  input  logic [CapW-1:0]  cap_i,
  output logic [1:0]       status_o,
  output logic [FlowW-1:0] flow_o
);

  logic [InfoW-1:0] info_mem [Pairs];
  logic [FlowW-1:0] flow_mem [Pairs];
  logic [EdgeW-1:0] par_mem  [Nodes];
  logic [NodeW-1:0] que_mem  [Nodes];

  logic [NcntW-1:0] ncnt_q;
  logic [PairW:0]   npair_q;
  logic [1:0]       act_q;
  logic [NodeW-1:0] src_q, dst_q, cur_q, loc_q;
  logic [CapW-1:0]  cap_q, bn_q;
  logic [Nodes-1:0] seen_q;
  logic [NodeW:0]   headp_q, tailp_q;
  logic [PairW:0]   k_q;
  logic [PairW-1:0] pk_q;
  logic             pv_q, run_q, sum_q, aug_q;
  logic [EdgeW-1:0] e_q, par_rd_q;
  logic [NodeW-1:0] q_rd_q;
  logic [InfoW-1:0] info_rd_q;
  logic [FlowW-1:0] flow_rd_q;
  logic signed [AccW-1:0] acc_q;
  logic [1:0]       status_q;
  logic [FlowW-1:0] flow_q;

  logic [PairW-1:0] rd_addr;
  logic [NodeW-1:0] rt, rh;
  logic [CapW-1:0]  rc;
  logic signed [FlowW:0] sf, res_even, res_odd, res_e;
  logic             in_range, full, issue, fwd_hit, rev_hit;
  logic [NodeW-1:0] hit_node, e_tail;
  logic signed [AccW-1:0] sf_acc;
  logic [FlowW-1:0] sat;

  assign in_range = ({1'b0, src_q} < ncnt_q) && ({1'b0, dst_q} < ncnt_q);
  assign full     = npair_q[PairW];
  assign rd_addr  = cmd_i.edge_rd ? par_rd_q[EdgeW-1:1] : k_q[PairW-1:0];
  assign issue    = run_q && (k_q != npair_q);

  assign rt = info_rd_q[InfoW-1 -: NodeW];
  assign rh = info_rd_q[InfoW-NodeW-1 -: NodeW];
  assign rc = info_rd_q[CapW-1:0];
  assign sf = {flow_rd_q[FlowW-1], flow_rd_q};
  assign res_even = $signed({2'b00, rc}) - sf;
  assign res_odd  = sf;
  assign res_e    = e_q[0] ? res_odd : res_even;
  assign e_tail   = e_q[0] ? rh : rt;

  assign fwd_hit  = (rt == cur_q) && !seen_q[rh] && (res_even > 0);
  assign rev_hit  = !fwd_hit && (rh == cur_q) && !seen_q[rt] && (res_odd > 0);
  assign hit_node = fwd_hit ? rh : rt;
  assign sf_acc   = AccW'(sf);

  always_comb begin
    if (acc_q < 0) begin
      sat = '0;
    end else if (acc_q[AccW-1:FlowW] != '0) begin
      sat = '1;
    end else begin
      sat = acc_q[FlowW-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    info_rd_q <= info_mem[rd_addr];
    flow_rd_q <= flow_mem[rd_addr];
    par_rd_q  <= par_mem[loc_q];
    q_rd_q    <= que_mem[headp_q[NodeW-1:0]];
    if (cmd_i.add_try && in_range && !full) begin
      info_mem[npair_q[PairW-1:0]] <= {src_q, dst_q, cap_q};
      flow_mem[npair_q[PairW-1:0]] <= '0;
    end else if (cmd_i.step && aug_q) begin
      flow_mem[e_q[EdgeW-1:1]] <= e_q[0] ? flow_rd_q - FlowW'(bn_q)
                                         : flow_rd_q + FlowW'(bn_q);
    end
    if (pv_q && !sum_q && (fwd_hit || rev_hit)) begin
      par_mem[hit_node] <= {pk_q, rev_hit};
    end
    if (cmd_i.init) begin
      que_mem[0] <= src_q;
    end else if (pv_q && !sum_q && (fwd_hit || rev_hit)) begin
      que_mem[tailp_q[NodeW-1:0]] <= hit_node;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      src_q <= from_i;
      dst_q <= to_i;
      cap_q <= cap_i;
    end
    if (cmd_i.deq) begin
      cur_q <= q_rd_q;
    end
    if (cmd_i.edge_rd) begin
      e_q <= par_rd_q;
    end
    if (issue) begin
      pk_q <= k_q[PairW-1:0];
    end
    if (cmd_i.path_go) begin
      bn_q <= '1;
    end else if (cmd_i.step && !aug_q && (res_e < $signed({2'b00, bn_q}))) begin
      bn_q <= res_e[CapW-1:0];
    end
    if (cmd_i.path_go || cmd_i.restart) begin
      loc_q <= dst_q;
    end else if (cmd_i.step) begin
      loc_q <= e_tail;
    end
    if (cmd_i.scan_go && cmd_i.scan_sum) begin
      acc_q <= '0;
    end else if (pv_q && sum_q) begin
      acc_q <= acc_q + ((rt == src_q) ? sf_acc : '0) - ((rh == src_q) ? sf_acc : '0);
    end
    if (cmd_i.set_resp) begin
      if ((act_q == ACT_ADD || act_q == ACT_RUN) && !in_range) begin
        status_q <= ST_RANGE;
        flow_q   <= '0;
      end else if (act_q == ACT_ADD && full) begin
        status_q <= ST_FULL;
        flow_q   <= '0;
      end else begin
        status_q <= ST_OK;
        flow_q   <= (act_q == ACT_RUN) ? sat : '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ncnt_q  <= NcntW'(Nodes);
      npair_q <= '0;
      act_q   <= ACT_ADD;
      seen_q  <= '0;
      headp_q <= '0;
      tailp_q <= '0;
      k_q     <= '0;
      pv_q    <= 1'b0;
      run_q   <= 1'b0;
      sum_q   <= 1'b0;
      aug_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        ncnt_q <= cfg_data_i;
      end
      if (cmd_i.latch) begin
        act_q <= act_i;
      end
      if (cmd_i.clr) begin
        npair_q <= '0;
      end else if (cmd_i.add_try && in_range && !full) begin
        npair_q <= npair_q + 1'b1;
      end
      if (cmd_i.init) begin
        seen_q         <= Nodes'(1) << src_q;
        headp_q        <= '0;
        tailp_q        <= (NodeW+1)'(1);
      end else begin
        if (cmd_i.deq) begin
          headp_q <= headp_q + 1'b1;
        end
        if (pv_q && !sum_q && (fwd_hit || rev_hit)) begin
          seen_q[hit_node] <= 1'b1;
          tailp_q          <= tailp_q + 1'b1;
        end
      end
      if (cmd_i.scan_go) begin
        run_q <= 1'b1;
        sum_q <= cmd_i.scan_sum;
        k_q   <= '0;
        pv_q  <= 1'b0;
      end else begin
        pv_q <= issue;
        if (issue) begin
          k_q <= k_q + 1'b1;
        end else if (!pv_q) begin
          run_q <= 1'b0;
        end
      end
      if (cmd_i.path_go) begin
        aug_q <= 1'b0;
      end else if (cmd_i.restart) begin
        aug_q <= 1'b1;
      end
    end
  end

  assign sts_o.act        = act_q;
  assign sts_o.in_range   = in_range;
  assign sts_o.src_eq_dst = (src_q == dst_q);
  assign sts_o.q_empty    = (headp_q == tailp_q);
  assign sts_o.hit_dst    = (q_rd_q == dst_q);
  assign sts_o.scan_busy  = run_q;
  assign sts_o.loc_is_src = (loc_q == src_q);
  assign sts_o.aug        = aug_q;

  assign status_o = status_q;
  assign flow_o   = flow_q;

endmodule

// File: hw/rtl/max_flow_bfs_augment_top.sv
// top level of the max-flow block
//   channel   direction  tuser          tdata
//   s_axis    in         action[1:0]    from[5:0] to[11:6] capacity[42:12]
//   m_axis    out        status[1:0]    max_flow[31:0]
//   cfg       in         -              node_count[6:0]
// add and clear go from decode straight to the result, which then waits on the output
// a run, per search, scans all edge pairs for each node dequeued, walks the path
// twice (bottleneck, then augment), and ends with a scan summing the source's net flow
// the edge table is two memories, each with a read and a write port, read one edge pair a cycle
// no input is taken while a result waits; reset needs no clearing pass
module max_flow_bfs_augment_top
  import mfba_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             s_axis_tvalid,
  output logic             s_axis_tready,
  input  logic [47:0]      s_axis_tdata,  // from, to, capacity
  input  logic [1:0]       s_axis_tuser,  // action
  output logic             m_axis_tvalid,
  input  logic             m_axis_tready,
  output logic [31:0]      m_axis_tdata,  // max_flow
  output logic [1:0]       m_axis_tuser,  // status
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [NcntW-1:0] cfg_data_i
);

  cmd_t cmd;
  sts_t sts;

  assign cfg_ready_o = 1'b1;

  mfba_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  mfba_dpath u_dpath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .cfg_we_i   (cfg_valid_i),
    .cfg_data_i (cfg_data_i),
    .act_i      (s_axis_tuser),
    .from_i     (s_axis_tdata[5:0]),
    .to_i       (s_axis_tdata[11:6]),
    .cap_i      (s_axis_tdata[42:12]),
    .status_o   (m_axis_tuser),
    .flow_o     (m_axis_tdata)
  );

endmodule

// File: hw/rtl/mfba_checker.sv
// port checker of the max-flow block and its bind
module mfba_checker
  import mfba_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [1:0]  m_axis_tuser
);

  a_no_take_while_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !s_axis_tready) else $error("input taken while word pending");

  a_busy_after_take: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("second word taken");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
    && $stable(m_axis_tuser)) else $error("result word changed while stalled");

  a_flow_only_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser != ST_OK |-> m_axis_tdata == 32'd0)
    else $error("flow on error status");

endmodule

bind max_flow_bfs_augment_top mfba_checker u_mfba_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

// File: tb/testbench.sv
// self-checking testbench of the max-flow block: edge loads, runs and clears
module testbench
  import mfba_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [1:0]  act;
    logic [5:0]  src;
    logic [5:0]  dst;
    logic [30:0] cap;
  } word_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [31:0] flow;
  } answer_t;

  logic clk_i = 0, rst_ni = 0;
  logic s_axis_tvalid = 0, s_axis_tready;
  logic [47:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = '0;
  logic m_axis_tvalid, m_axis_tready = 0;
  logic [31:0] m_axis_tdata;
  logic [1:0] m_axis_tuser;
  logic cfg_valid_i = 0, cfg_ready_o;
  logic [NcntW-1:0] cfg_data_i = '0;

  max_flow_bfs_augment_top u_top (.*);

  // predictor state
  int unsigned nodes_in_use = 64;
  logic [5:0]  tab_tail [512];
  logic [5:0]  tab_head [512];
  logic [30:0] tab_cap [512];
  logic [31:0] tab_flow [512];
  int unsigned tab_used = 0;
  int unsigned via [64];

  word_t   pending_words[$];
  answer_t expected_answers[$];
  int fails = 0;
  int send_idle = 0, recv_stall = 0;
  logic busy_pause = 0;

  function automatic void queue_word(word_t w);
    pending_words = {pending_words, w};
  endfunction

  function automatic void queue_answer(answer_t a);
    expected_answers = {expected_answers, a};
  endfunction

  function automatic longint residual_of(int unsigned e);
    return longint'(tab_cap[e]) - longint'($signed(tab_flow[e]));
  endfunction

  function automatic bit find_path(int unsigned s, int unsigned t);
    bit seen [64];
    int unsigned fifo [64];
    int unsigned rd, wr, cur, n;
    rd = 0; wr = 0;
    foreach (seen[i]) seen[i] = 0;
    seen[s] = 1; fifo[wr++] = s;
    while (rd < wr) begin
      cur = fifo[rd++];
      if (cur == t) return 1;
      for (int unsigned e = 0; e < tab_used; e++) begin
        if (tab_tail[e] != cur) continue;
        n = tab_head[e];
        if (seen[n] || residual_of(e) <= 0) continue;
        seen[n] = 1; via[n] = e;
        if (wr < 64) fifo[wr++] = n;
      end
    end
    return 0;
  endfunction

  function automatic logic [31:0] push_max_flow(int unsigned s, int unsigned t);
    longint total, neck, r;
    int unsigned loc;
    total = 0;
    if (s != t) begin
      while (find_path(s, t)) begin
        neck = 64'h7FFF_FFFF;
        for (loc = t; loc != s; loc = tab_tail[via[loc]]) begin
          r = residual_of(via[loc]);
          if (r < neck) neck = r;
        end
        for (loc = t; loc != s; loc = tab_tail[via[loc]]) begin
          tab_flow[via[loc]] += neck[31:0];
          tab_flow[via[loc] ^ 1] -= neck[31:0];
        end
      end
    end
    for (int unsigned e = 0; e < tab_used; e++)
      if (tab_tail[e] == s) total += longint'($signed(tab_flow[e]));
    if (total < 0) return 0;
    if (total > 64'hFFFF_FFFF) return 32'hFFFF_FFFF;
    return total[31:0];
  endfunction

  function automatic answer_t predict_answer(word_t w);
    answer_t a;
    bit ok;
    a = '0;
    ok = w.src < nodes_in_use && w.dst < nodes_in_use;
    case (w.act)
      ACT_ADD: begin
        if (!ok) a.status = ST_RANGE;
        else if (tab_used + 2 > 512) a.status = ST_FULL;
        else begin
          tab_tail[tab_used] = w.src; tab_head[tab_used] = w.dst;
          tab_cap[tab_used] = w.cap; tab_flow[tab_used] = 0;
          tab_tail[tab_used+1] = w.dst; tab_head[tab_used+1] = w.src;
          tab_cap[tab_used+1] = 0; tab_flow[tab_used+1] = 0;
          tab_used += 2;
        end
      end
      ACT_RUN: begin
        if (!ok) a.status = ST_RANGE;
        else a.flow = push_max_flow(w.src, w.dst);
      end
      ACT_CLEAR: tab_used = 0;
      default: ;
    endcase
    return a;
  endfunction

  initial forever #10 clk_i = ~clk_i;

  // driver
  always @(posedge clk_i) begin
    word_t w;
    if (s_axis_tvalid && s_axis_tready) begin
      w = {s_axis_tuser, s_axis_tdata[5:0], s_axis_tdata[11:6], s_axis_tdata[42:12]};
      queue_answer(predict_answer(w));
    end
    if (!(s_axis_tvalid && !s_axis_tready)) begin
      if (pending_words.size() > 0 && !(busy_pause && pending_words.size() == 1) &&
          !(send_idle > 0 && $urandom_range(99) < send_idle)) begin
        w = pending_words.pop_front();
        s_axis_tvalid <= 1;
        s_axis_tuser <= w.act;
        s_axis_tdata <= {5'b0, w.cap, w.dst, w.src};
      end else s_axis_tvalid <= 0;
    end
    m_axis_tready <= !(recv_stall > 0 && $urandom_range(99) < recv_stall);
  end

  // monitor
  always @(posedge clk_i) begin
    answer_t e;
    if (m_axis_tvalid && m_axis_tready) begin
      if (expected_answers.size() == 0) begin
        $display("%0t unexpected word status %0d flow %0d", $time, m_axis_tuser,
                 m_axis_tdata);
        fails++;
      end else begin
        e = expected_answers.pop_front();
        if (e.status !== m_axis_tuser || e.flow !== m_axis_tdata) begin
          $display("%0t mismatch expected status %0d flow %0d actual status %0d flow %0d",
                   $time, e.status, e.flow, m_axis_tuser, m_axis_tdata);
          fails++;
        end
      end
    end
  end

  function automatic word_t mk(logic [1:0] act, int unsigned s, int unsigned d,
                               int unsigned c);
    word_t w;
    w.act = act; w.src = 6'(s); w.dst = 6'(d); w.cap = 31'(c);
    return w;
  endfunction

  task automatic drain();
    while (pending_words.size() > 0 || s_axis_tvalid || expected_answers.size() > 0)
      @(posedge clk_i);
    repeat (3000) @(posedge clk_i);
  endtask

  task automatic write_nodes(int unsigned n);
    @(posedge clk_i);
    cfg_valid_i <= 1; cfg_data_i <= NcntW'(n);
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 0;
    nodes_in_use = n;
  endtask

  function automatic word_t rand_word(int unsigned span);
    int r;
    r = $urandom_range(99);
    if (r < 55) return mk(ACT_ADD, $urandom_range(span-1), $urandom_range(span-1),
                          ($urandom_range(3) == 0) ? $urandom : $urandom_range(40));
    if (r < 85) return mk(ACT_RUN, $urandom_range(span-1), $urandom_range(span-1), $urandom);
    if (r < 92) return mk(ACT_CLEAR, $urandom, $urandom, $urandom);
    if (r < 96) return mk(2'd3, $urandom, $urandom, $urandom);
    return mk(2'($urandom_range(1)), $urandom, $urandom, $urandom);
  endfunction

  task automatic random_phase(int count, int span, int si, int rs);
    send_idle = si; recv_stall = rs;
    for (int i = 0; i < count; i++) begin
      if (i % 40 == 0) queue_word(mk(ACT_CLEAR, 0, 0, 0));
      queue_word(rand_word(span));
    end
    drain();
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    // directed
    queue_word(mk(ACT_ADD, 0, 1, 31'h7FFF_FFFF));
    queue_word(mk(ACT_ADD, 0, 1, 31'h7FFF_FFFF));
    queue_word(mk(ACT_ADD, 0, 1, 31'h7FFF_FFFF));
    queue_word(mk(ACT_ADD, 1, 63, 31'h7FFF_FFFF));
    queue_word(mk(ACT_ADD, 1, 63, 31'h7FFF_FFFF));
    queue_word(mk(ACT_ADD, 1, 63, 0));
    queue_word(mk(ACT_RUN, 0, 63, 0));
    queue_word(mk(ACT_RUN, 0, 0, 0));
    queue_word(mk(ACT_RUN, 63, 0, 0));
    queue_word(mk(ACT_RUN, 1, 0, 0));
    queue_word(mk(2'd3, 63, 63, 31'h7FFF_FFFF));
    queue_word(mk(ACT_CLEAR, 0, 0, 0));
    queue_word(mk(ACT_RUN, 0, 63, 0));
    drain();
    write_nodes(1);
    queue_word(mk(ACT_ADD, 0, 1, 5));
    queue_word(mk(ACT_ADD, 0, 0, 5));
    queue_word(mk(ACT_RUN, 0, 0, 0));
    queue_word(mk(ACT_RUN, 1, 0, 0));
    drain();
    write_nodes(64);
    for (int i = 0; i < 257; i++)
      queue_word(mk(ACT_ADD, i % 8, (i + 1) % 8, $urandom_range(9)));
    queue_word(mk(ACT_RUN, 0, 7, 0));
    busy_pause = 1;
    send_idle = 0; recv_stall = 0;
    while (pending_words.size() > 1 || s_axis_tvalid || expected_answers.size() > 0)
      @(posedge clk_i);
    busy_pause = 0;
    drain();
    write_nodes(8);
    random_phase(180, 64, 0, 0);
    write_nodes(64);
    random_phase(140, 12, 84, 0);
    write_nodes(20);
    random_phase(140, 24, 0, 84);
    write_nodes(5);
    random_phase(110, 8, 33, 33);
    write_nodes(64);
    random_phase(80, 64, 0, 0);
    if (fails == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #200ms;
    $display("*** FAILED ***");
    $finish;
  end
endmodule
